>>> rtl/als_pkg.sv
// Shared types and constants for the addressable LED serializer.
`timescale 1ns / 1ps

package als_pkg;

    // Bits in one reordered pixel word (green, red, blue)
    localparam int unsigned WORD_BITS = 24;
    localparam int unsigned CNT_W     = 5;
    localparam int unsigned TICK_W    = 10;
    localparam int unsigned GAP_W     = 16;

    // Register indexes on the configuration port (byte address / 4)
    localparam logic [1:0] REG_ZERO_HIGH  = 2'd0;
    localparam logic [1:0] REG_ONE_HIGH   = 2'd1;
    localparam logic [1:0] REG_BIT_PERIOD = 2'd2;
    localparam logic [1:0] REG_RESET_GAP  = 2'd3;

    // Reset values, set for a 48 MHz clock
    localparam logic [TICK_W-1:0] ZERO_HIGH_RST  = 10'd19;
    localparam logic [TICK_W-1:0] ONE_HIGH_RST   = 10'd38;
    localparam logic [TICK_W-1:0] BIT_PERIOD_RST = 10'd60;
    localparam logic [GAP_W-1:0]  RESET_GAP_RST  = 16'd2400;

    // Timing registers as seen by the encoder
    typedef struct packed {
        logic [TICK_W-1:0] zero_high;
        logic [TICK_W-1:0] one_high;
        logic [TICK_W-1:0] bit_period;
        logic [GAP_W-1:0]  reset_gap;
    } t_timing;

    // One tick offered to the encoder
    typedef struct packed {
        logic       pixel_offer;
        logic [7:0] red;
        logic [7:0] green;
        logic [7:0] blue;
        logic       frame_end;
    } t_tick_in;

    // One tick of encoder output
    typedef struct packed {
        logic underrun;
        logic busy_res;
        logic pixel_taken;
        logic line_level;
    } t_tick_out;

endpackage

>>> rtl/als_encoder.sv
// Pixel holding register, bit shifter and pulse timing of the LED serializer.
`timescale 1ns / 1ps

module als_encoder
    import als_pkg::*;
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_step,
    input  t_tick_in  i_tick,
    input  t_timing   i_timing,
    output t_tick_out o_result
);

    logic [WORD_BITS-1:0] r_shift_word, n_shift_word;
    logic                 r_shifting_last, n_shifting_last;
    logic [WORD_BITS-1:0] r_hold_word, n_hold_word;
    logic                 r_hold_valid, n_hold_valid;
    logic                 r_hold_last, n_hold_last;
    logic [CNT_W-1:0]     r_bits_left, n_bits_left;
    logic [TICK_W-1:0]    r_tick_in_bit, n_tick_in_bit;
    logic [GAP_W-1:0]     r_gap_left, n_gap_left;

    logic              load_idle;
    logic [TICK_W-1:0] high_ticks;
    logic [TICK_W:0]   tick_next;
    logic [CNT_W-1:0]  bits_dec;

    // Compute one tick of the encoder
    always_comb begin
        n_shift_word    = r_shift_word;
        n_shifting_last = r_shifting_last;
        n_hold_word     = r_hold_word;
        n_hold_valid    = r_hold_valid;
        n_hold_last     = r_hold_last;
        n_bits_left     = r_bits_left;
        n_tick_in_bit   = r_tick_in_bit;
        n_gap_left      = r_gap_left;
        o_result        = '0;

        // Idle with a pixel held: move it to the shifter on this tick
        load_idle = (r_bits_left == '0) && (r_gap_left == '0) && r_hold_valid;
        if (load_idle) begin
            n_shift_word    = r_hold_word;
            n_shifting_last = r_hold_last;
            n_hold_valid    = 1'b0;
            n_bits_left     = CNT_W'(WORD_BITS);
            n_tick_in_bit   = '0;
        end

        high_ticks = n_shift_word[WORD_BITS-1] ? i_timing.one_high : i_timing.zero_high;
        tick_next  = {1'b0, n_tick_in_bit} + 1'b1;
        bits_dec   = n_bits_left - 1'b1;

        if (n_bits_left != '0) begin
            o_result.busy_res = 1'b1;
            o_result.line_level = (high_ticks >= i_timing.bit_period) ||
                                  (n_tick_in_bit < high_ticks);
            if (tick_next >= {1'b0, i_timing.bit_period}) begin
                // Bit done: advance to the next bit
                n_tick_in_bit = '0;
                n_shift_word  = {n_shift_word[WORD_BITS-2:0], 1'b0};
                n_bits_left   = bits_dec;
                if (bits_dec == '0) begin
                    if (n_shifting_last) begin
                        n_gap_left      = i_timing.reset_gap;
                        n_shifting_last = 1'b0;
                    end else if (n_hold_valid) begin
                        n_shift_word    = r_hold_word;
                        n_shifting_last = r_hold_last;
                        n_hold_valid    = 1'b0;
                        n_bits_left     = CNT_W'(WORD_BITS);
                    end else begin
                        o_result.underrun = 1'b1;
                    end
                end
            end else begin
                n_tick_in_bit = tick_next[TICK_W-1:0];
            end
        end else if (r_gap_left != '0) begin
            // Hold the line low through the reset gap
            o_result.busy_res = 1'b1;
            n_gap_left        = r_gap_left - 1'b1;
        end

        // Take an offered pixel only if the holding register was empty
        if (i_tick.pixel_offer && !r_hold_valid) begin
            n_hold_word          = {i_tick.green, i_tick.red, i_tick.blue};
            n_hold_last          = i_tick.frame_end;
            n_hold_valid         = 1'b1;
            o_result.pixel_taken = 1'b1;
        end
    end

    // Update state on each processed tick
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_shift_word    <= '0;
            r_shifting_last <= 1'b0;
            r_hold_word     <= '0;
            r_hold_valid    <= 1'b0;
            r_hold_last     <= 1'b0;
            r_bits_left     <= '0;
            r_tick_in_bit   <= '0;
            r_gap_left      <= '0;
        end else if (i_step) begin
            r_shift_word    <= n_shift_word;
            r_shifting_last <= n_shifting_last;
            r_hold_word     <= n_hold_word;
            r_hold_valid    <= n_hold_valid;
            r_hold_last     <= n_hold_last;
            r_bits_left     <= n_bits_left;
            r_tick_in_bit   <= n_tick_in_bit;
            r_gap_left      <= n_gap_left;
        end
    end

endmodule

>>> rtl/addressable_led_serializer.sv
// Top level of the addressable LED serializer: stream ports, registers, encoder.
//
//  Channel   Direction  Payload
//  s_axis    in         tdata {blue, green, red}, tuser pixel_offer, tlast frame_end
//  m_axis    out        tdata {underrun, busy_res, pixel_taken, line_level}
//  APB       in/out     timing registers at 0x0, 0x4, 0x8, 0xC
//
// One transfer in yields one transfer out; a tick can be taken every cycle
// while the output is not stalled. A tick passes an input register, then the
// encoder step into the output register. The encoder advances only when its
// input register holds a tick and the output register is free or being
// drained, so stalls on either side just pause the line timing. Synchronous
// reset clears valid flags and encoder state and loads 48 MHz timing defaults.
`timescale 1ns / 1ps

module addressable_led_serializer
    import als_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    // Input stream
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [23:0] s_axis_tdata,   // [7:0] red, [15:8] green, [23:16] blue
    input  logic        s_axis_tuser,   // [0] pixel_offer
    input  logic        s_axis_tlast,
    // Output stream
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [7:0]  m_axis_tdata,   // [0] line_level, [1] pixel_taken,
                                        // [2] busy_res, [3] underrun, rest zero
    // Configuration port
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [3:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    t_timing   r_timing;
    logic      r_in_valid;
    t_tick_in  r_in_tick;
    logic      r_out_valid;
    t_tick_out r_out;
    t_tick_out step_out;
    logic      step;
    logic      cfg_wr;
    logic [1:0] reg_idx;

    assign pready  = 1'b1;
    assign cfg_wr  = psel && penable && pwrite;
    assign reg_idx = paddr[3:2];

    // Write timing registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_timing.zero_high  <= ZERO_HIGH_RST;
            r_timing.one_high   <= ONE_HIGH_RST;
            r_timing.bit_period <= BIT_PERIOD_RST;
            r_timing.reset_gap  <= RESET_GAP_RST;
        end else if (cfg_wr) begin
            case (reg_idx)
                REG_ZERO_HIGH:  r_timing.zero_high  <= pwdata[TICK_W-1:0];
                REG_ONE_HIGH:   r_timing.one_high   <= pwdata[TICK_W-1:0];
                REG_BIT_PERIOD: r_timing.bit_period <= pwdata[TICK_W-1:0];
                REG_RESET_GAP:  r_timing.reset_gap  <= pwdata[GAP_W-1:0];
                default: ;
            endcase
        end
    end

    // Read back timing registers
    always_comb begin
        case (reg_idx)
            REG_ZERO_HIGH:  prdata = {22'd0, r_timing.zero_high};
            REG_ONE_HIGH:   prdata = {22'd0, r_timing.one_high};
            REG_BIT_PERIOD: prdata = {22'd0, r_timing.bit_period};
            REG_RESET_GAP:  prdata = {16'd0, r_timing.reset_gap};
            default:        prdata = '0;
        endcase
    end

    // Step the encoder when a tick is held and the output can take a result
    assign step          = r_in_valid && (!r_out_valid || m_axis_tready);
    assign s_axis_tready = !r_in_valid || step;

    // Input register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (s_axis_tready) begin
            r_in_valid <= s_axis_tvalid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s_axis_tvalid && s_axis_tready) begin
            r_in_tick.pixel_offer <= s_axis_tuser;
            r_in_tick.red         <= s_axis_tdata[7:0];
            r_in_tick.green       <= s_axis_tdata[15:8];
            r_in_tick.blue        <= s_axis_tdata[23:16];
            r_in_tick.frame_end   <= s_axis_tlast;
        end
    end

    als_encoder u_encoder (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_step   (step),
        .i_tick   (r_in_tick),
        .i_timing (r_timing),
        .o_result (step_out)
    );

    // Output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (step) begin
            r_out_valid <= 1'b1;
        end else if (m_axis_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (step) begin
            r_out <= step_out;
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = {4'd0, r_out};

endmodule
